/* hdl/ist_pkg.sv */
// ----------------------------------------------------------------------------
// ist_pkg: shared types and constants for the integer set table
// Table capacity, derived widths, request codes and status codes.
// ----------------------------------------------------------------------------
package ist_pkg;

  // table geometry
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ALREADY = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_FULL    = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SHIFT = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

/* hdl/ist_ram.sv */
// ----------------------------------------------------------------------------
// ist_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/integer_set_table_top.sv */
// ----------------------------------------------------------------------------
// integer_set_table_top: ordered set of distinct signed 32-bit integers
// Insert, delete, membership lookup and indexed read over a small table.
// ----------------------------------------------------------------------------
// The set lives in a CAPACITY-entry RAM with one write and one read port, in
// insertion order, plus a live count. Insert, delete and lookup scan the live
// entries one per cycle through the RAM read port; delete then moves every
// later entry down one place, again one entry per cycle. The block takes one
// beat at a time; a finished result sits in the output register while the
// next beat is accepted.
// Reads at or beyond the live count return ST_RANGE and entry_value 0.
module integer_set_table_top import ist_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic signed [31:0] value,
  input  logic [3:0]         index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               present,
  output logic [2:0]         status,
  output logic [4:0]         count,
  output logic signed [31:0] entry_value
);

  state_t              state;
  req_t                req;
  logic [DATA_W-1:0]   val;
  logic [CNT_W-1:0]    live_count;
  logic [CNT_W-1:0]    ptr;       // next address to read
  logic                pend;      // a read issued last cycle has data now
  logic [ADDR_W-1:0]   wr_ptr;    // destination of the pending move
  logic                res_present;
  status_t             res_status;
  logic [DATA_W-1:0]   res_entry;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [DATA_W-1:0]   rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]   wr_data;

  logic                hit;
  logic                more;
  logic                idx_ok;

  assign in_ready = (state == S_IDLE);
  assign hit      = pend && (rd_data == val);
  assign more     = (ptr < live_count);
  assign idx_ok   = (CNT_W'(index) < live_count);

  // RAM port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = wr_ptr;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_addr = ADDR_W'(index);
        rd_en   = in_valid && (req_t'(req_type) == REQ_READ) && idx_ok;
      end
      S_SCAN: begin
        rd_en   = !hit && more;
        wr_addr = live_count[ADDR_W-1:0];
        wr_data = val;
        wr_en   = !hit && !more && !pend && (req == REQ_INSERT) &&
                  (live_count != CNT_W'(CAPACITY));
      end
      S_SHIFT: begin
        rd_en = more;
        wr_en = pend;
      end
      S_READ, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      ptr        <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // output beat taken; S_DONE refills the register itself
      if (out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req         <= req_t'(req_type);
            val         <= value;
            ptr         <= '0;
            pend        <= 1'b0;
            res_present <= 1'b0;
            res_status  <= ST_OK;
            res_entry   <= '0;
            if (req_t'(req_type) == REQ_READ) begin
              if (idx_ok) begin
                state <= S_READ;
              end else begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            // match at ptr - 1; a delete moves entries from ptr onward
            res_present <= 1'b1;
            pend        <= 1'b0;
            if (req == REQ_DELETE) begin
              state <= S_SHIFT;
            end else begin
              if (req == REQ_INSERT) begin
                res_status <= ST_ALREADY;
              end
              state <= S_DONE;
            end
          end else if (more) begin
            ptr  <= ptr + CNT_W'(1);
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            // scan finished, value absent
            if (req == REQ_INSERT) begin
              if (live_count == CNT_W'(CAPACITY)) begin
                res_status <= ST_FULL;
              end else begin
                live_count <= live_count + CNT_W'(1);
              end
            end else begin
              res_status <= ST_ABSENT;
            end
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          // read entry ptr now, write it to ptr - 1 next cycle
          if (more) begin
            wr_ptr <= ADDR_W'(ptr - CNT_W'(1));
            ptr    <= ptr + CNT_W'(1);
            pend   <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            live_count <= live_count - CNT_W'(1);
            state      <= S_DONE;
          end
        end
        S_READ: begin
          res_entry <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            present     <= res_present;
            status      <= res_status;
            count       <= live_count;
            entry_value <= res_entry;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ist_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule
